// File: rtl/median_filter_2d_replicate_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the 2-D median filter
// Immediate-consequence and next-cycle implication checks with reset gating.
// ----------------------------------------------------------------------------
`ifndef MEDIAN_FILTER_2D_REPLICATE_ASSERT_SVH
`define MEDIAN_FILTER_2D_REPLICATE_ASSERT_SVH

// Consequence must hold in the same cycle as the antecedent.
`define MF2D_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("implication check failed");

// Consequence must hold in the cycle after the antecedent.
`define MF2D_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// File: rtl/mf2d_pkg.sv
// ----------------------------------------------------------------------------
// mf2d_pkg
// Shared constants, codes, types and tables of the 2-D median filter.
// ----------------------------------------------------------------------------
package mf2d_pkg;

    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_RADIUS_DEF = 3;
    localparam int HEIGHT_LIMIT   = 4096;
    localparam int ROW_W          = 12;
    localparam int HGT_W          = 13;
    localparam int CFG_W_W        = 11;
    localparam int CFG_H_W        = 13;
    localparam int CFG_R_W        = 2;
    localparam int CFG_DATA_W     = 13;
    localparam int CFG_IDX_W      = 2;
    localparam int PIX_W          = 8;
    localparam int QUEUE_DEPTH    = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WIDTH,
        CFG_HEIGHT,
        CFG_RADIUS
    } t_cfg_idx;

    typedef enum logic {
        CMD_PIXEL,
        CMD_DRAIN
    } t_cmd;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_GATHER,
        BK_DRAIN,
        BK_OUT
    } t_bk_state;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    typedef struct packed {
        logic idle;
        logic done;
    } t_bk_stat;

    // window size (2r+1)^2
    function automatic logic [5:0] win_count(input logic [CFG_R_W-1:0] r);
        logic [5:0] n;
        unique case (r)
            2'd1:    n = 6'd9;
            2'd2:    n = 6'd25;
            default: n = 6'd49;
        endcase
        return n;
    endfunction

    // position of the middle element in the sorted window
    function automatic logic [5:0] med_index(input logic [CFG_R_W-1:0] r);
        logic [5:0] m;
        unique case (r)
            2'd1:    m = 6'd4;
            2'd2:    m = 6'd12;
            default: m = 6'd24;
        endcase
        return m;
    endfunction

endpackage

// File: rtl/mf2d_if.sv
// ----------------------------------------------------------------------------
// mf2d_if
// Valid/ready channels for incoming pixel transactions and filtered results.
// ----------------------------------------------------------------------------
interface mf2d_pix_if;
    logic       valid;
    logic       ready;
    logic       command;
    logic [7:0] pixel;
    modport source (output valid, command, pixel, input ready);
    modport sink (input valid, command, pixel, output ready);
endinterface

interface mf2d_res_if;
    logic       valid;
    logic       ready;
    logic [7:0] filtered_pixel;
    logic       last_of_frame;
    modport source (output valid, filtered_pixel, last_of_frame, input ready);
    modport sink (input valid, filtered_pixel, last_of_frame, output ready);
endinterface

// File: rtl/median_filter_2d_replicate.sv
// Path: a transaction that makes a result due queues a job; the engine walks its
// window through gather, drain and out, then registers the result for the sink.
// Throughput: the front takes one transaction per cycle while its two-job queue
// has room; the engine finishes one window before it takes the next, walking it
// pixel by pixel through the line store's single read port.
// Reset: synchronous; clears positions, queue and engine, loads 640x480 r=3.
// ----------------------------------------------------------------------------
// median_filter_2d_replicate
// Streaming 2-D median over a (2r+1)-square window with edge replication.
// ----------------------------------------------------------------------------
`include "median_filter_2d_replicate_assert.svh"

module median_filter_2d_replicate #(
    parameter int MAX_WIDTH  = mf2d_pkg::MAX_WIDTH_DEF,
    parameter int MAX_RADIUS = mf2d_pkg::MAX_RADIUS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    mf2d_pix_if.sink                         i_pix,
    mf2d_res_if.source                       o_res,
    input  logic                             i_cfg_we,
    input  logic [mf2d_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [mf2d_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    localparam int DEPTH = (2*MAX_RADIUS+1)*MAX_WIDTH;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int WW    = $clog2(MAX_WIDTH+1);
    localparam int RW    = mf2d_pkg::ROW_W;
    localparam int HW    = mf2d_pkg::HGT_W;
    localparam int JW    = AW + RW + CW + 1;

    // configuration registers, as written
    logic [mf2d_pkg::CFG_W_W-1:0] r_cfg_w;
    logic [mf2d_pkg::CFG_H_W-1:0] r_cfg_h;
    logic [mf2d_pkg::CFG_R_W-1:0] r_cfg_r;

    // geometry in use after clamping
    logic [WW-1:0]                w_w;
    logic [HW-1:0]                w_h;
    logic [mf2d_pkg::CFG_R_W-1:0] w_r;

    logic                         w_push, w_pop;
    logic [AW-1:0]                w_job_rd, w_q_rd;
    logic [RW-1:0]                w_job_row, w_q_row;
    logic [CW-1:0]                w_job_col, w_q_col;
    logic                         w_job_last, w_q_last;
    logic [JW-1:0]                w_q_out;
    logic                         w_wr_en;
    logic [AW-1:0]                w_wr_addr;
    logic [mf2d_pkg::PIX_W-1:0]   w_wr_data;
    logic                         w_bk_ready;
    mf2d_pkg::t_q_stat            w_q_stat;
    mf2d_pkg::t_bk_stat           w_bk_stat;

    // take register writes; an index beyond the list is dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w <= mf2d_pkg::CFG_W_W'(640);
            r_cfg_h <= mf2d_pkg::CFG_H_W'(480);
            r_cfg_r <= mf2d_pkg::CFG_R_W'(3);
        end else if (i_cfg_we) begin
            unique case (mf2d_pkg::t_cfg_idx'(i_cfg_idx))
                mf2d_pkg::CFG_WIDTH:  r_cfg_w <= i_cfg_data[mf2d_pkg::CFG_W_W-1:0];
                mf2d_pkg::CFG_HEIGHT: r_cfg_h <= i_cfg_data[mf2d_pkg::CFG_H_W-1:0];
                mf2d_pkg::CFG_RADIUS: r_cfg_r <= i_cfg_data[mf2d_pkg::CFG_R_W-1:0];
                default: ;
            endcase
        end
    end

    // zero means one; clamp above the supported limits
    always_comb begin
        if (r_cfg_w == '0) begin
            w_w = WW'(1);
        end else if (32'(r_cfg_w) > MAX_WIDTH) begin
            w_w = WW'(MAX_WIDTH);
        end else begin
            w_w = WW'(r_cfg_w);
        end
        if (r_cfg_h == '0) begin
            w_h = HW'(1);
        end else if (32'(r_cfg_h) > mf2d_pkg::HEIGHT_LIMIT) begin
            w_h = HW'(mf2d_pkg::HEIGHT_LIMIT);
        end else begin
            w_h = r_cfg_h;
        end
        if (r_cfg_r == '0) begin
            w_r = mf2d_pkg::CFG_R_W'(1);
        end else if (32'(r_cfg_r) > MAX_RADIUS) begin
            w_r = mf2d_pkg::CFG_R_W'(MAX_RADIUS);
        end else begin
            w_r = r_cfg_r;
        end
    end

    // front: store pixels, count pending results, queue window jobs
    mf2d_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_RADIUS (MAX_RADIUS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_pix.valid),
        .i_command  (i_pix.command),
        .i_pixel    (i_pix.pixel),
        .o_ready    (i_pix.ready),
        .i_w        (w_w),
        .i_h        (w_h),
        .i_r        (w_r),
        .i_q        (w_q_stat),
        .o_push     (w_push),
        .o_job_rd   (w_job_rd),
        .o_job_row  (w_job_row),
        .o_job_col  (w_job_col),
        .o_job_last (w_job_last),
        .o_wr_en    (w_wr_en),
        .o_wr_addr  (w_wr_addr),
        .o_wr_data  (w_wr_data)
    );

    // job queue: centre address, output position and end-of-frame flag
    mf2d_fifo #(
        .W     (JW),
        .DEPTH (mf2d_pkg::QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  ({w_job_last, w_job_col, w_job_row, w_job_rd}),
        .i_pop   (w_pop),
        .o_data  (w_q_out),
        .o_stat  (w_q_stat)
    );

    assign w_pop = w_bk_ready && !w_q_stat.empty;
    assign {w_q_last, w_q_col, w_q_row, w_q_rd} = w_q_out;

    // back: gather the window, sort and hold the result for the sink
    mf2d_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_RADIUS (MAX_RADIUS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_w         (w_w),
        .i_h         (w_h),
        .i_r         (w_r),
        .i_wr_en     (w_wr_en),
        .i_wr_addr   (w_wr_addr),
        .i_wr_data   (w_wr_data),
        .i_job_valid (!w_q_stat.empty),
        .i_job_rd    (w_q_rd),
        .i_job_row   (w_q_row),
        .i_job_col   (w_q_col),
        .i_job_last  (w_q_last),
        .o_job_ready (w_bk_ready),
        .o_valid     (o_res.valid),
        .i_ready     (o_res.ready),
        .o_pixel     (o_res.filtered_pixel),
        .o_last      (o_res.last_of_frame),
        .o_stat      (w_bk_stat)
    );

    // a job is never pushed into a full queue, so none is lost
    `MF2D_IMPLY(a_push_room, i_clk, i_rst_n, w_push, !w_q_stat.full)
    // a finished window always shows up on the result channel
    `MF2D_NEXT(a_done_shows, i_clk, i_rst_n, w_bk_stat.done, o_res.valid)
    // a job leaves the queue only into an idle engine
    `MF2D_IMPLY(a_pop_idle, i_clk, i_rst_n, w_pop, w_bk_stat.idle && !w_bk_stat.done)
endmodule

// File: rtl/mf2d_fifo.sv
// ----------------------------------------------------------------------------
// mf2d_fifo
// Short job queue between the front tracker and the window engine.
// ----------------------------------------------------------------------------
module mf2d_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = mf2d_pkg::QUEUE_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [W-1:0]      i_data,
    input  logic              i_pop,
    output logic [W-1:0]      o_data,
    output mf2d_pkg::t_q_stat o_stat
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]  r_mem [DEPTH];
    logic [PW-1:0] r_wp, r_rp;
    logic [CW-1:0] r_cnt;
    logic          w_push, w_pop;

    assign o_stat.full  = (r_cnt == CW'(DEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign w_push = i_push && !o_stat.full;
    assign w_pop  = i_pop && !o_stat.empty;
    assign o_data = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + PW'(1);
            end
            if (w_pop) begin
                r_rp <= (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + PW'(1);
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end
endmodule

// File: rtl/mf2d_front.sv
// ----------------------------------------------------------------------------
// mf2d_front
// Take pixel and drain transactions, store pixels, track raster positions
// and queue one window job per result due.
// ----------------------------------------------------------------------------
module mf2d_front #(
    parameter int MAX_WIDTH  = mf2d_pkg::MAX_WIDTH_DEF,
    parameter int MAX_RADIUS = mf2d_pkg::MAX_RADIUS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic                          i_command,
    input  logic [mf2d_pkg::PIX_W-1:0]    i_pixel,
    output logic                          o_ready,
    input  logic [$clog2(MAX_WIDTH+1)-1:0] i_w,
    input  logic [mf2d_pkg::HGT_W-1:0]    i_h,
    input  logic [mf2d_pkg::CFG_R_W-1:0]  i_r,
    input  mf2d_pkg::t_q_stat             i_q,
    output logic                          o_push,
    output logic [$clog2((2*MAX_RADIUS+1)*MAX_WIDTH)-1:0] o_job_rd,
    output logic [mf2d_pkg::ROW_W-1:0]    o_job_row,
    output logic [$clog2(MAX_WIDTH)-1:0]  o_job_col,
    output logic                          o_job_last,
    output logic                          o_wr_en,
    output logic [$clog2((2*MAX_RADIUS+1)*MAX_WIDTH)-1:0] o_wr_addr,
    output logic [mf2d_pkg::PIX_W-1:0]    o_wr_data
);
    localparam int DEPTH = (2*MAX_RADIUS+1)*MAX_WIDTH;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int WW    = $clog2(MAX_WIDTH+1);
    localparam int PW    = AW + 1;
    localparam int RW    = mf2d_pkg::ROW_W;
    localparam int HW    = mf2d_pkg::HGT_W;

    logic [CW-1:0] r_in_col, r_out_col, n_in_col, n_out_col;
    logic [RW-1:0] r_in_row, r_out_row, n_in_row, n_out_row;
    logic [AW-1:0] r_wr, r_rd;
    logic [PW-1:0] r_pend;
    logic [WW+1:0] w_lag;
    logic          w_acc, w_pix, w_emit;

    assign o_ready = !i_q.full;
    assign w_acc   = i_valid && !i_q.full;
    assign w_pix   = (mf2d_pkg::t_cmd'(i_command) == mf2d_pkg::CMD_PIXEL);
    assign w_lag   = (WW+2)'(i_r) * (WW+2)'(i_w) + (WW+2)'(i_r);

    always_comb begin
        if (w_pix) begin
            w_emit = w_acc && ((r_pend + PW'(1)) > PW'(w_lag));
        end else begin
            w_emit = w_acc && (r_pend != '0) && (r_in_row == '0) && (r_in_col == '0);
        end
    end

    // raster advance with wrap at the frame bounds
    always_comb begin
        if ((WW'(r_in_col) + WW'(1)) >= i_w) begin
            n_in_col = '0;
            n_in_row = ((HW'(r_in_row) + HW'(1)) >= i_h) ? '0 : r_in_row + RW'(1);
        end else begin
            n_in_col = r_in_col + CW'(1);
            n_in_row = r_in_row;
        end
        if ((WW'(r_out_col) + WW'(1)) >= i_w) begin
            n_out_col = '0;
            n_out_row = ((HW'(r_out_row) + HW'(1)) >= i_h) ? '0 : r_out_row + RW'(1);
        end else begin
            n_out_col = r_out_col + CW'(1);
            n_out_row = r_out_row;
        end
    end

    assign o_push     = w_emit;
    assign o_job_rd   = r_rd;
    assign o_job_row  = r_out_row;
    assign o_job_col  = r_out_col;
    assign o_job_last = (HW'(r_out_row) == i_h - HW'(1)) && (WW'(r_out_col) == i_w - WW'(1));
    assign o_wr_en    = w_acc && w_pix;
    assign o_wr_addr  = r_wr;
    assign o_wr_data  = i_pixel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
            r_wr      <= '0;
            r_rd      <= '0;
            r_pend    <= '0;
        end else begin
            if (w_acc && w_pix) begin
                r_in_col <= n_in_col;
                r_in_row <= n_in_row;
                r_wr     <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + AW'(1);
            end
            if (w_emit) begin
                r_out_col <= n_out_col;
                r_out_row <= n_out_row;
                r_rd      <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + AW'(1);
            end
            if (w_acc && w_pix && !w_emit) begin
                r_pend <= r_pend + PW'(1);
            end else if (w_emit && !w_pix) begin
                r_pend <= r_pend - PW'(1);
            end
        end
    end
endmodule

// File: rtl/mf2d_back.sv
// ----------------------------------------------------------------------------
// mf2d_back
// Window engine: hold the line store, fetch one window pixel per cycle,
// insertion-sort it and present the middle value.
// ----------------------------------------------------------------------------
module mf2d_back #(
    parameter int MAX_WIDTH  = mf2d_pkg::MAX_WIDTH_DEF,
    parameter int MAX_RADIUS = mf2d_pkg::MAX_RADIUS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [$clog2(MAX_WIDTH+1)-1:0] i_w,
    input  logic [mf2d_pkg::HGT_W-1:0]    i_h,
    input  logic [mf2d_pkg::CFG_R_W-1:0]  i_r,
    input  logic                          i_wr_en,
    input  logic [$clog2((2*MAX_RADIUS+1)*MAX_WIDTH)-1:0] i_wr_addr,
    input  logic [mf2d_pkg::PIX_W-1:0]    i_wr_data,
    input  logic                          i_job_valid,
    input  logic [$clog2((2*MAX_RADIUS+1)*MAX_WIDTH)-1:0] i_job_rd,
    input  logic [mf2d_pkg::ROW_W-1:0]    i_job_row,
    input  logic [$clog2(MAX_WIDTH)-1:0]  i_job_col,
    input  logic                          i_job_last,
    output logic                          o_job_ready,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [mf2d_pkg::PIX_W-1:0]    o_pixel,
    output logic                          o_last,
    output mf2d_pkg::t_bk_stat            o_stat
);
    localparam int DEPTH = (2*MAX_RADIUS+1)*MAX_WIDTH;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int WW    = $clog2(MAX_WIDTH+1);
    localparam int RW    = mf2d_pkg::ROW_W;
    localparam int HW    = mf2d_pkg::HGT_W;
    localparam int PXW   = mf2d_pkg::PIX_W;
    localparam int WMAX  = (2*MAX_RADIUS+1)*(2*MAX_RADIUS+1);
    localparam int SW    = $clog2(WMAX+1);
    localparam int SI    = $clog2(WMAX);
    localparam int YW    = RW + 3;
    localparam int XW    = CW + 4;
    localparam int OW    = AW + 2;

    mf2d_pkg::t_bk_state r_state, n_state;

    logic [PXW-1:0] r_mem [DEPTH];
    logic [AW-1:0]  r_rd, r_addr, w_addr;
    logic [RW-1:0]  r_row;
    logic [CW-1:0]  r_col;
    logic           r_job_last;
    logic [2:0]     r_dr, r_dc, w_side;
    logic           r_a_vld, r_q_vld;
    logic [PXW-1:0] r_q;
    logic [PXW-1:0] r_sort [WMAX];
    logic [PXW-1:0] w_ins  [WMAX];
    logic [WMAX-1:0] w_le;
    logic [SW-1:0]  r_cnt;
    logic [PXW-1:0] r_res;
    logic           r_last, r_o_vld;
    logic           w_start, w_issue, w_load;
    logic [5:0]     w_mid6;
    logic [SI-1:0]  w_mid;

    logic signed [YW-1:0] w_ys, w_yc, w_dy;
    logic signed [XW-1:0] w_xs, w_xc, w_dx, w_xmax;
    logic signed [3:0]    w_dy4, w_dx4;
    logic signed [OW-1:0] w_sum;

    assign w_side = {i_r, 1'b0};
    assign w_mid6 = mf2d_pkg::med_index(i_r);
    assign w_mid  = w_mid6[SI-1:0];

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mf2d_pkg::BK_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        w_start = 1'b0;
        w_issue = 1'b0;
        w_load  = 1'b0;
        unique case (r_state)
            mf2d_pkg::BK_IDLE: begin
                if (i_job_valid) begin
                    w_start = 1'b1;
                    n_state = mf2d_pkg::BK_GATHER;
                end
            end
            mf2d_pkg::BK_GATHER: begin
                w_issue = 1'b1;
                if (r_dr == w_side && r_dc == w_side) begin
                    n_state = mf2d_pkg::BK_DRAIN;
                end
            end
            mf2d_pkg::BK_DRAIN: begin
                if (r_cnt == SW'(mf2d_pkg::win_count(i_r))) begin
                    n_state = mf2d_pkg::BK_OUT;
                end
            end
            mf2d_pkg::BK_OUT: begin
                if (!r_o_vld || i_ready) begin
                    w_load  = 1'b1;
                    n_state = mf2d_pkg::BK_IDLE;
                end
            end
            default: n_state = mf2d_pkg::BK_IDLE;
        endcase
    end

    assign o_job_ready = (r_state == mf2d_pkg::BK_IDLE);
    assign o_stat.idle = (r_state == mf2d_pkg::BK_IDLE);
    assign o_stat.done = w_load;

    // window address: clamp row and column to the frame, then offset the
    // centre address in the circular store
    always_comb begin
        w_ys = $signed(YW'(r_row)) + $signed(YW'(r_dr)) - $signed(YW'(i_r));
        if (w_ys < 0) begin
            w_yc = '0;
        end else if (w_ys > $signed(YW'(i_h)) - YW'(1)) begin
            w_yc = $signed(YW'(i_h)) - YW'(1);
        end else begin
            w_yc = w_ys;
        end
        w_dy  = w_yc - $signed(YW'(r_row));
        w_dy4 = w_dy[3:0];

        w_xmax = $signed(XW'(i_w)) - XW'(1);
        w_xs   = $signed(XW'(r_col)) + $signed(XW'(r_dc)) - $signed(XW'(i_r));
        if (w_xs < 0) begin
            w_xc = '0;
        end else if (w_xs > w_xmax) begin
            w_xc = w_xmax;
        end else begin
            w_xc = w_xs;
        end
        w_dx  = w_xc - $signed(XW'(r_col));
        w_dx4 = w_dx[3:0];

        w_sum = $signed(OW'(r_rd)) + OW'(w_dy4) * $signed(OW'(i_w)) + OW'(w_dx4);
        if (w_sum < 0) begin
            w_sum = w_sum + $signed(OW'(DEPTH));
        end else if (w_sum >= $signed(OW'(DEPTH))) begin
            w_sum = w_sum - $signed(OW'(DEPTH));
        end
        w_addr = w_sum[AW-1:0];
    end

    // insertion into the sorted window
    always_comb begin
        for (int i = 0; i < WMAX; i++) begin
            w_le[i] = (SW'(i) < r_cnt) && (r_sort[i] <= r_q);
        end
        for (int i = 0; i < WMAX; i++) begin
            if (w_le[i]) begin
                w_ins[i] = r_sort[i];
            end else if (i == 0) begin
                w_ins[i] = r_q;
            end else if (w_le[(i > 0) ? i - 1 : 0]) begin
                w_ins[i] = r_q;
            end else begin
                w_ins[i] = r_sort[(i > 0) ? i - 1 : 0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_q <= r_mem[r_addr];
    end

    always_ff @(posedge i_clk) begin
        if (w_start) begin
            r_rd       <= i_job_rd;
            r_row      <= i_job_row;
            r_col      <= i_job_col;
            r_job_last <= i_job_last;
        end
        if (w_issue) begin
            r_addr <= w_addr;
        end
        if (r_q_vld) begin
            for (int i = 0; i < WMAX; i++) begin
                r_sort[i] <= w_ins[i];
            end
        end
        if (w_load) begin
            r_res  <= r_sort[w_mid];
            r_last <= r_job_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dr    <= '0;
            r_dc    <= '0;
            r_a_vld <= 1'b0;
            r_q_vld <= 1'b0;
            r_cnt   <= '0;
            r_o_vld <= 1'b0;
        end else begin
            r_a_vld <= w_issue;
            r_q_vld <= r_a_vld;
            if (w_start) begin
                r_dr  <= '0;
                r_dc  <= '0;
                r_cnt <= '0;
            end else begin
                if (w_issue) begin
                    if (r_dc == w_side) begin
                        r_dc <= '0;
                        r_dr <= r_dr + 3'd1;
                    end else begin
                        r_dc <= r_dc + 3'd1;
                    end
                end
                if (r_q_vld) begin
                    r_cnt <= r_cnt + SW'(1);
                end
            end
            if (w_load) begin
                r_o_vld <= 1'b1;
            end else if (i_ready) begin
                r_o_vld <= 1'b0;
            end
        end
    end

    assign o_valid = r_o_vld;
    assign o_pixel = r_res;
    assign o_last  = r_last;
endmodule

// File: tb/mf2d_checker.sv
// ----------------------------------------------------------------------------
// mf2d_checker
// Watches the pixel, result and register ports of the 2-D median filter,
// predicts each filtered pixel and compares it with what the block returns.
// ----------------------------------------------------------------------------
module mf2d_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    mf2d_pix_if                              pix,
    mf2d_res_if                              res,
    input  logic                             i_cfg_we,
    input  logic [mf2d_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [mf2d_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output int                               o_failures,
    output int                               o_outstanding
);
    import mf2d_pkg::*;

    localparam int STORE_DEPTH = (2 * MAX_RADIUS_DEF + 1) * MAX_WIDTH_DEF;

    typedef struct packed {
        logic [PIX_W-1:0] filtered_pixel;
        logic             last_of_frame;
    } t_filtered;

    logic [PIX_W-1:0] line_mem [STORE_DEPTH];
    int unsigned      width_reg, height_reg, radius_reg;
    int unsigned      in_col, in_row, out_col, out_row;
    int unsigned      wr_ptr, rd_ptr, backlog;
    t_filtered        due_q [$];

    function automatic int unsigned eff_width();
        return (width_reg == 0) ? 1 : (width_reg > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : width_reg;
    endfunction

    function automatic int unsigned eff_height();
        return (height_reg == 0) ? 1 : (height_reg > HEIGHT_LIMIT) ? HEIGHT_LIMIT : height_reg;
    endfunction

    function automatic int unsigned eff_radius();
        return (radius_reg == 0) ? 1 : (radius_reg > MAX_RADIUS_DEF) ? MAX_RADIUS_DEF : radius_reg;
    endfunction

    function automatic void step_raster(ref int unsigned col, ref int unsigned row,
                                        input int unsigned w, input int unsigned h);
        if (col + 1 >= w) begin
            col = 0;
            row = (row + 1 >= h) ? 0 : row + 1;
        end else begin
            col = col + 1;
        end
    endfunction

    // Median of the replicated-border window around the output position; advance it.
    function automatic t_filtered next_median();
        int          w, h, r, rr, cc, off, addr, n, j;
        logic [7:0]  win [49];
        logic [7:0]  v;
        t_filtered   f;
        w = eff_width();
        h = eff_height();
        r = eff_radius();
        n = 0;
        for (int dr = -r; dr <= r; dr++) begin
            rr = int'(out_row) + dr;
            if (rr < 0) rr = 0;
            if (rr > h - 1) rr = h - 1;
            for (int dc = -r; dc <= r; dc++) begin
                cc = int'(out_col) + dc;
                if (cc < 0) cc = 0;
                if (cc > w - 1) cc = w - 1;
                off = (rr - int'(out_row)) * w + (cc - int'(out_col));
                addr = (int'(rd_ptr) + off) % STORE_DEPTH;
                if (addr < 0) addr += STORE_DEPTH;
                win[n] = line_mem[addr];
                n++;
            end
        end
        for (int i = 1; i < n; i++) begin
            v = win[i];
            j = i - 1;
            while (j >= 0 && win[j] > v) begin
                win[j + 1] = win[j];
                j--;
            end
            win[j + 1] = v;
        end
        f.filtered_pixel = win[n / 2];
        f.last_of_frame  = (out_row == h - 1 && out_col == w - 1);
        step_raster(out_col, out_row, w, h);
        rd_ptr = (rd_ptr + 1) % STORE_DEPTH;
        if (backlog > 0) backlog--;
        return f;
    endfunction

    always @(posedge i_clk) begin
        t_filtered got, want;
        if (!i_rst_n) begin
            width_reg  = 640;
            height_reg = 480;
            radius_reg = 3;
            in_col = 0; in_row = 0; out_col = 0; out_row = 0;
            wr_ptr = 0; rd_ptr = 0; backlog = 0;
            due_q.delete();
            o_failures = 0;
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_WIDTH:  width_reg  = i_cfg_data[CFG_W_W-1:0];
                    CFG_HEIGHT: height_reg = i_cfg_data[CFG_H_W-1:0];
                    CFG_RADIUS: radius_reg = i_cfg_data[CFG_R_W-1:0];
                    default: ;
                endcase
            end
            if (res.valid && res.ready) begin
                got.filtered_pixel = res.filtered_pixel;
                got.last_of_frame  = res.last_of_frame;
                if (due_q.size() == 0) begin
                    $error("result with none due: filtered_pixel %0d", got.filtered_pixel);
                    o_failures++;
                end else begin
                    want = due_q.pop_front();
                    if (got.filtered_pixel !== want.filtered_pixel) begin
                        $error("filtered_pixel: expected %0d, actual %0d",
                               want.filtered_pixel, got.filtered_pixel);
                        o_failures++;
                    end
                    if (got.last_of_frame !== want.last_of_frame) begin
                        $error("last_of_frame: expected %0d, actual %0d",
                               want.last_of_frame, got.last_of_frame);
                        o_failures++;
                    end
                end
            end
            if (pix.valid && pix.ready) begin
                if (t_cmd'(pix.command) == CMD_PIXEL) begin
                    line_mem[wr_ptr] = pix.pixel;
                    wr_ptr = (wr_ptr + 1) % STORE_DEPTH;
                    step_raster(in_col, in_row, eff_width(), eff_height());
                    backlog++;
                    if (backlog > eff_radius() * eff_width() + eff_radius())
                        due_q.push_back(next_median());
                end else if (backlog > 0 && in_row == 0 && in_col == 0) begin
                    due_q.push_back(next_median());
                end
            end
        end
        o_outstanding = due_q.size();
    end

endmodule

// File: tb/tb_median_filter_2d_replicate.sv
// ----------------------------------------------------------------------------
// tb_median_filter_2d_replicate
// Drives frames of grey pixels and drain transactions into the 2-D median
// filter under random gaps and stalls, over several geometries including the
// zero register values; a checker predicts every result.
// ----------------------------------------------------------------------------
module tb_median_filter_2d_replicate;
    import mf2d_pkg::*;

    // Cycles without any accepted transaction before the run is declared hung.
    // The limit is far above the longest engine walk of one window plus the
    // longest random ready stall and the settling pause: several times the worst case.
    localparam int HANG_LIMIT   = 4000;
    localparam int SETTLE_TICKS = 64;
    localparam int TOTAL_ITEMS  = 1050;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    failures;
    int                    outstanding;

    mf2d_pix_if pix ();
    mf2d_res_if res ();

    // Burst flags: when set, the side concerned neither idles nor stalls.
    bit tx_burst;
    bit rx_burst;
    int sent_items;
    int unsigned eff_w, eff_h, eff_r;
    int idle_cycles;

    median_filter_2d_replicate dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_pix      (pix.sink),
        .o_res      (res.source),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    mf2d_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .pix           (pix),
        .res           (res),
        .i_cfg_we      (cfg_we),
        .i_cfg_idx     (cfg_idx),
        .i_cfg_data    (cfg_data),
        .o_failures    (failures),
        .o_outstanding (outstanding)
    );

    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    // Watchdog: count cycles in which neither channel moves a transaction.
    always @(posedge i_clk) begin
        if (!i_rst_n || (pix.valid && pix.ready) || (res.valid && res.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= HANG_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Result side: stall a random number of cycles, then hold ready until a
    // transaction is taken. Valid is sampled on the falling edge so the
    // decision never races the block's own update at the rising edge.
    initial begin
        int  stall;
        bit  taken;
        @(posedge i_rst_n);
        forever begin
            stall = rx_burst ? 0 : $urandom_range(0, 17);
            if (stall > 0) begin
                res.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            res.ready <= 1'b1;
            do begin
                @(negedge i_clk);
                taken = res.valid;
                @(posedge i_clk);
            end while (!taken);
        end
    end

    // Offer one transaction after a random gap; hold it until accepted.
    task automatic push_item(input t_cmd cmd, input logic [PIX_W-1:0] value);
        int gap;
        bit taken;
        gap = tx_burst ? 0 : $urandom_range(0, 17);
        if (gap > 0) begin
            pix.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        pix.valid   <= 1'b1;
        pix.command <= cmd;
        pix.pixel   <= value;
        do begin
            @(negedge i_clk);
            taken = pix.ready;
            @(posedge i_clk);
        end while (!taken);
        sent_items++;
    endtask

    // Drop valid, wait for every predicted result, then let the engine go
    // quiet before anything touches the registers.
    task automatic settle();
        pix.valid <= 1'b0;
        do @(negedge i_clk); while (outstanding != 0);
        repeat (SETTLE_TICKS) @(posedge i_clk);
    endtask

    // Write all three registers; only called with the block idle.
    task automatic configure(input int unsigned w, input int unsigned h, input int unsigned r);
        cfg_we <= 1'b1; cfg_idx <= CFG_WIDTH;  cfg_data <= CFG_DATA_W'(w);
        @(posedge i_clk);
        cfg_idx <= CFG_HEIGHT; cfg_data <= CFG_DATA_W'(h);
        @(posedge i_clk);
        cfg_idx <= CFG_RADIUS; cfg_data <= CFG_DATA_W'(r);
        @(posedge i_clk);
        cfg_we <= 1'b0;
        // Mirror the block's clamping so frames and drains are sized right.
        w &= 11'h7FF; h &= 13'h1FFF; r &= 2'h3;
        eff_w = (w == 0) ? 1 : (w > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : w;
        eff_h = (h == 0) ? 1 : (h > HEIGHT_LIMIT) ? HEIGHT_LIMIT : h;
        eff_r = (r == 0) ? 1 : (r > MAX_RADIUS_DEF) ? MAX_RADIUS_DEF : r;
    endtask

    // One whole frame of pixels; with noise, stray drains fall among the pixels
    // (they give nothing unless results are still pending at the frame's start).
    task automatic send_frame(input int style, input bit noise);
        logic [PIX_W-1:0] value;
        for (int i = 0; i < eff_w * eff_h; i++) begin
            if (noise && $urandom_range(0, 19) == 0)
                push_item(CMD_DRAIN, PIX_W'($urandom));
            case (style)
                0:       value = PIX_W'($urandom);
                1:       value = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                2:       value = PIX_W'($urandom_range(120, 136));
                default: value = PIX_W'(i);
            endcase
            push_item(CMD_PIXEL, value);
        end
    endtask

    // Release the tail of the frame; a couple of spare drains find nothing.
    task automatic flush(input int spare);
        repeat (eff_r * eff_w + eff_r + spare) push_item(CMD_DRAIN, PIX_W'($urandom));
        settle();
    endtask

    initial begin
        logic [PIX_W-1:0] probe [9];
        bit               pair;
        i_rst_n     = 1'b0;
        cfg_we      = 1'b0;
        cfg_idx     = CFG_WIDTH;
        cfg_data    = '0;
        pix.valid   = 1'b0;
        pix.command = CMD_PIXEL;
        pix.pixel   = '0;
        res.ready   = 1'b0;
        tx_burst    = 1'b0;
        rx_burst    = 1'b0;
        sent_items  = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: a drain straight after reset has nothing to release.
        push_item(CMD_DRAIN, 8'hFF);
        settle();

        // Directed 3x3 frame, r=1: extreme values, a mid-frame drain, drain tail.
        configure(3, 3, 1);
        probe = '{8'h00, 8'hFF, 8'h01, 8'hFE, 8'h80, 8'h7F, 8'hAA, 8'h55, 8'hFF};
        for (int i = 0; i < 9; i++) begin
            push_item(CMD_PIXEL, probe[i]);
            if (i == 4) push_item(CMD_DRAIN, 8'h00);
        end
        flush(2);

        // Single-pixel frame with r=2: the window is the pixel replicated.
        configure(1, 1, 2);
        push_item(CMD_PIXEL, 8'hC3);
        flush(1);

        // Widest small frame at r=3, sent back to back.
        tx_burst = 1'b1;
        configure(16, 4, 3);
        send_frame(0, 1'b0);
        flush(0);
        tx_burst = 1'b0;

        // Zero width and radius become 1.
        rx_burst = 1'b1;
        configure(0, 20, 0);
        send_frame(1, 1'b0);
        flush(1);
        rx_burst = 1'b0;

        // Random frames of small geometry, sometimes two back to back
        // without draining between them.
        while (sent_items < TOTAL_ITEMS) begin
            tx_burst = ($urandom_range(0, 3) == 0);
            rx_burst = ($urandom_range(0, 3) == 0);
            configure($urandom_range(0, 16), $urandom_range(0, 12), $urandom_range(0, 3));
            pair = ($urandom_range(0, 3) == 0);
            send_frame($urandom_range(0, 3), $urandom_range(0, 1));
            if (pair) send_frame($urandom_range(0, 3), $urandom_range(0, 1));
            flush($urandom_range(0, 2));
        end

        // Everything drained by the last settle; give the verdict.
        if (failures == 0 && outstanding == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
